// ===== rtl/core/moce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moce_pkg
// Shared types, register indexes and the direction table of the outline
// copy expander.
// ----------------------------------------------------------------------------
package moce_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 65535;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned CFG_IDX_W        = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_OUTLINE_COLOR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_HORIZONTAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_VERTICAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_DIRECTIONS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLY_ALPHA    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICES_PER_COPY = 3'd5;

  localparam logic [3:0] COPY_ORIGINAL = 4'd0;
  localparam logic [3:0] COPY_FIRST    = 4'd1;
  localparam logic [3:0] COPY_FOUR     = 4'd4;
  localparam logic [3:0] COPY_EIGHT    = 4'd8;

  localparam logic MODE_VERTEX = 1'b0;
  localparam logic MODE_INDEX  = 1'b1;

  typedef enum logic [1:0] {
    KCNT_NONE,
    KCNT_FOUR,
    KCNT_EIGHT
  } kcnt_e;

  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sgn_e;

  typedef struct packed {
    sgn_e h;
    sgn_e v;
  } dir_t;

  typedef struct packed {
    logic [31:0]        outline_color;
    logic signed [31:0] offset_horizontal;
    logic signed [31:0] offset_vertical;
    logic               eight_directions;
    logic               multiply_alpha;
    logic [15:0]        vertices_per_copy;
  } cfg_t;

  // One classified item as it travels from front to back
  typedef struct packed {
    logic               mode;
    kcnt_e              kcnt;
    logic signed [31:0] pos_horizontal;
    logic signed [31:0] pos_vertical;
    logic [31:0]        color;
    logic [63:0]        texcoord;
    logic [15:0]        tri_index;
  } item_t;

  typedef struct packed {
    logic [3:0]         copy_number;
    logic signed [31:0] out_horizontal;
    logic signed [31:0] out_vertical;
    logic [31:0]        out_color;
    logic [63:0]        out_texcoord;
    logic [15:0]        out_index;
    logic               status;
    logic               last;
  } res_t;

  function automatic dir_t copy_dir(logic [3:0] copy);
    dir_t d;
    unique case (copy)
      4'd1:    d = '{h: SGN_POS,  v: SGN_POS};
      4'd2:    d = '{h: SGN_NEG,  v: SGN_POS};
      4'd3:    d = '{h: SGN_POS,  v: SGN_NEG};
      4'd4:    d = '{h: SGN_NEG,  v: SGN_NEG};
      4'd5:    d = '{h: SGN_NEG,  v: SGN_ZERO};
      4'd6:    d = '{h: SGN_POS,  v: SGN_ZERO};
      4'd7:    d = '{h: SGN_ZERO, v: SGN_POS};
      4'd8:    d = '{h: SGN_ZERO, v: SGN_NEG};
      default: d = '{h: SGN_ZERO, v: SGN_ZERO};
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/mesh_outline_copy_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_outline_copy_expander
// Expands UI mesh vertices and triangle indices into outline copies.
// ----------------------------------------------------------------------------
// The output side delivers one result per cycle while pop keeps up, so a
// vertex item yields K results (8 or 4 copies, or 1 when the mesh is too
// large for an outline) and an index item K+1 (1 when too large); this rate
// is set by the copy sequencer in the back stage, which steps one copy per
// unstalled cycle into a single output register. Items pass a front register
// that picks K and scales the outline alpha, a two-entry queue and the back
// item register before the output register, so a new item is taken while the
// previous one is still expanding. Configuration writes are registered and
// must be made only while no item is in flight.
// ----------------------------------------------------------------------------
module mesh_outline_copy_expander #(
  parameter int unsigned MAX_VERTICES = moce_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [moce_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           mode_i,
  input  logic signed [31:0]             pos_horizontal_i,
  input  logic signed [31:0]             pos_vertical_i,
  input  logic [7:0]                     source_alpha_i,
  input  logic [63:0]                    texcoord_bits_i,
  input  logic [15:0]                    tri_index_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [3:0]                     copy_number_o,
  output logic signed [31:0]             out_horizontal_o,
  output logic signed [31:0]             out_vertical_o,
  output logic [31:0]                    out_color_o,
  output logic [63:0]                    out_texcoord_o,
  output logic [15:0]                    out_index_o,
  output logic                           status_o,
  output logic                           last_o
);
  import moce_pkg::*;

  cfg_t  cfg;
  item_t wr_item, rd_item;
  logic  q_wr, q_full, q_rd, q_empty;
  res_t  res;

  moce_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  moce_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .pos_horizontal_i (pos_horizontal_i),
    .pos_vertical_i   (pos_vertical_i),
    .source_alpha_i   (source_alpha_i),
    .texcoord_bits_i  (texcoord_bits_i),
    .tri_index_i      (tri_index_i),
    .q_wr_o           (q_wr),
    .q_item_o         (wr_item),
    .q_full_i         (q_full)
  );

  moce_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (wr_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_item_o (rd_item),
    .empty_o   (q_empty)
  );

  moce_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_item_i  (rd_item),
    .q_empty_i (q_empty),
    .q_rd_o    (q_rd),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res)
  );

  assign copy_number_o    = res.copy_number;
  assign out_horizontal_o = res.out_horizontal;
  assign out_vertical_o   = res.out_vertical;
  assign out_color_o      = res.out_color;
  assign out_texcoord_o   = res.out_texcoord;
  assign out_index_o      = res.out_index;
  assign status_o         = res.status;
  assign last_o           = res.last;

endmodule

// ===== rtl/core/moce_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moce_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module moce_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [moce_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output moce_pkg::cfg_t                 cfg_o
);
  import moce_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OUTLINE_COLOR:     cfg_d.outline_color     = cfg_data_i;
        CFG_OFFSET_HORIZONTAL: cfg_d.offset_horizontal = cfg_data_i;
        CFG_OFFSET_VERTICAL:   cfg_d.offset_vertical   = cfg_data_i;
        CFG_EIGHT_DIRECTIONS:  cfg_d.eight_directions  = cfg_data_i[0];
        CFG_MULTIPLY_ALPHA:    cfg_d.multiply_alpha    = cfg_data_i[0];
        CFG_VERTICES_PER_COPY: cfg_d.vertices_per_copy = cfg_data_i[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outline_color     <= 32'hFF00_0000;
      cfg_q.offset_horizontal <= 32'sd65536;
      cfg_q.offset_vertical   <= 32'sd65536;
      cfg_q.eight_directions  <= 1'b0;
      cfg_q.multiply_alpha    <= 1'b1;
      cfg_q.vertices_per_copy <= 16'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/moce_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moce_front
// Input stage: accepts items, picks the copy count and scales the outline
// alpha, then hands the classified item to the queue.
// ----------------------------------------------------------------------------
module moce_front #(
  parameter int unsigned MAX_VERTICES = moce_pkg::MAX_VERTICES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  moce_pkg::cfg_t        cfg_i,
  input  logic                  push,
  output logic                  full,
  input  logic                  mode_i,
  input  logic signed [31:0]    pos_horizontal_i,
  input  logic signed [31:0]    pos_vertical_i,
  input  logic [7:0]            source_alpha_i,
  input  logic [63:0]           texcoord_bits_i,
  input  logic [15:0]           tri_index_i,
  output logic                  q_wr_o,
  output moce_pkg::item_t       q_item_o,
  input  logic                  q_full_i
);
  import moce_pkg::*;

  localparam int unsigned VertW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CmpW  = (VertW > 20) ? VertW : 20;

  logic            valid_q, valid_d;
  item_t           item_q, item_d;
  logic            accept;
  logic [CmpW-1:0] n_ext, n5, n9, max_v;
  kcnt_e           kcnt;
  logic [15:0]     alpha_prod, alpha_sum;
  logic [7:0]      alpha;

  assign q_wr_o   = valid_q && !q_full_i;
  assign q_item_o = item_q;
  assign full     = valid_q && q_full_i;
  assign accept   = push && !full;

  assign n_ext = CmpW'(cfg_i.vertices_per_copy);
  assign n5    = (n_ext << 2) + n_ext;
  assign n9    = (n_ext << 3) + n_ext;
  assign max_v = CmpW'(MAX_VERTICES);

  always_comb begin
    priority if (cfg_i.vertices_per_copy == 16'd0 || n5 > max_v) begin
      kcnt = KCNT_NONE;
    end else if (cfg_i.eight_directions && n9 <= max_v) begin
      kcnt = KCNT_EIGHT;
    end else begin
      kcnt = KCNT_FOUR;
    end
  end

  // floor(p / 255) for p up to 255*255
  assign alpha_prod = 16'(source_alpha_i) * 16'(cfg_i.outline_color[31:24]);
  assign alpha_sum  = alpha_prod + (alpha_prod >> 8) + 16'd1;
  assign alpha      = alpha_sum[15:8];

  always_comb begin
    item_d.mode           = mode_i;
    item_d.kcnt           = kcnt;
    item_d.pos_horizontal = pos_horizontal_i;
    item_d.pos_vertical   = pos_vertical_i;
    item_d.color          = cfg_i.multiply_alpha ?
                            {alpha, cfg_i.outline_color[23:0]} : cfg_i.outline_color;
    item_d.texcoord       = texcoord_bits_i;
    item_d.tri_index      = tri_index_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_wr_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/core/moce_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moce_fifo
// Short queue of classified items between the front and back stages.
// ----------------------------------------------------------------------------
module moce_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  moce_pkg::item_t wr_item_i,
  output logic            full_o,
  input  logic            rd_i,
  output moce_pkg::item_t rd_item_o,
  output logic            empty_o
);
  import moce_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  item_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntFull);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count missed a write");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/core/moce_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moce_back
// Copy sequencer: walks the copies of the item at the queue head and
// emits one result per cycle into the output register while pop keeps up.
// ----------------------------------------------------------------------------
module moce_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  moce_pkg::cfg_t  cfg_i,
  input  moce_pkg::item_t q_item_i,
  input  logic            q_empty_i,
  output logic            q_rd_o,
  output logic            empty,
  input  logic            pop,
  output moce_pkg::res_t  res_o
);
  import moce_pkg::*;

  logic        busy_q, busy_d;
  item_t       item_q;
  logic [3:0]  copy_q, copy_d;
  logic [15:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;
  logic        emit;
  logic [3:0]  copy_max;
  dir_t        dir;

  function automatic logic signed [31:0] sat_shift(logic signed [31:0] pos,
                                                   logic signed [31:0] off,
                                                   sgn_e sgn);
    logic signed [33:0] off_x;
    logic signed [33:0] sum;
    unique case (sgn)
      SGN_POS: off_x = 34'(off);
      SGN_NEG: off_x = -34'(off);
      default: off_x = '0;
    endcase
    sum = 34'(pos) + off_x;
    if (!sum[33] && sum[32:31] != 2'b00) begin
      return 32'sh7FFF_FFFF;
    end else if (sum[33] && sum[32:31] != 2'b11) begin
      return 32'sh8000_0000;
    end
    return sum[31:0];
  endfunction

  assign emit     = busy_q && (!out_valid_q || pop);
  assign copy_max = (item_q.kcnt == KCNT_EIGHT) ? COPY_EIGHT : COPY_FOUR;
  assign dir      = copy_dir(copy_q);

  always_comb begin
    res_d = '0;
    if (item_q.kcnt == KCNT_NONE) begin
      res_d.status = 1'b1;
      res_d.last   = 1'b1;
      if (item_q.mode == MODE_INDEX) begin
        res_d.out_index = item_q.tri_index;
      end
    end else if (item_q.mode == MODE_INDEX) begin
      res_d.copy_number = copy_q;
      res_d.out_index   = (copy_q == COPY_ORIGINAL) ? item_q.tri_index : acc_q;
      res_d.last        = (copy_q == COPY_ORIGINAL);
    end else begin
      res_d.copy_number    = copy_q;
      res_d.out_horizontal = sat_shift(item_q.pos_horizontal,
                                       cfg_i.offset_horizontal, dir.h);
      res_d.out_vertical   = sat_shift(item_q.pos_vertical,
                                       cfg_i.offset_vertical, dir.v);
      res_d.out_color      = item_q.color;
      res_d.out_texcoord   = item_q.texcoord;
      res_d.last           = (copy_q == copy_max);
    end
  end

  // take the next item when idle or as the current one emits its last result
  assign q_rd_o = !q_empty_i && (!busy_q || (emit && res_d.last));

  always_comb begin
    busy_d = busy_q;
    copy_d = copy_q;
    acc_d  = acc_q;
    if (emit) begin
      acc_d  = acc_q + cfg_i.vertices_per_copy;
      copy_d = (item_q.mode == MODE_INDEX && copy_q == copy_max) ?
               COPY_ORIGINAL : copy_q + 4'd1;
      if (res_d.last) begin
        busy_d = 1'b0;
      end
    end
    if (q_rd_o) begin
      busy_d = 1'b1;
      copy_d = (q_item_i.kcnt == KCNT_NONE) ? COPY_ORIGINAL : COPY_FIRST;
      acc_d  = q_item_i.tri_index + cfg_i.vertices_per_copy;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      copy_q      <= COPY_ORIGINAL;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      copy_q      <= copy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (q_rd_o) begin
      item_q <= q_item_i;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign empty = !out_valid_q;
  assign res_o = res_q;

  a_copy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> copy_q <= COPY_EIGHT)
    else $error("copy counter out of range");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status) |-> res_q.last)
    else $error("mesh-too-large result not marked last");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(res_q)))
    else $error("output register changed while stalled");

  a_idle_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !out_valid_q) |=> !out_valid_q || $past(q_rd_o) == 1'b0)
    else $error("result emitted without an item");

endmodule
